FILE: hdl/plc_pkg.sv
// shared types and constants for the positional character list
`timescale 1ns / 1ps

package plc_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int CHAR_W   = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_READ
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CNT_W-1:0]  position;
        logic [CHAR_W-1:0] character;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CHAR_W-1:0] read_character;
        logic [CNT_W-1:0]  list_length;
    } rsp_t;

endpackage

FILE: hdl/plc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module plc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/positional_char_list_top.sv
// top level of the positional character list: control, length register and list memory
// sequence: an invalid position or a full list is answered straight from idle; a read
//   goes through S_READ; an insert or delete moves the entries behind the position in S_SHIFT
// requests: one at a time, busy while not idle; every moved entry passes through the
//   single read and single write port of the list memory
// reset: length cleared, controller idle; memory contents undefined until written
// results appear for one cycle on done and cannot be stalled
`timescale 1ns / 1ps

module positional_char_list_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  plc_pkg::req_t request,
    output logic          done,
    output plc_pkg::rsp_t result
);

    localparam int ADDR_W = plc_pkg::ADDR_W;
    localparam int CNT_W  = plc_pkg::CNT_W;
    localparam int CHAR_W = plc_pkg::CHAR_W;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(plc_pkg::CAPACITY);

    plc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [ADDR_W-1:0] at_reg, at_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              ins_reg, ins_next;
    logic              pend_reg, pend_next;
    logic              done_reg, done_next;
    plc_pkg::rsp_t     result_reg, result_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic [CNT_W:0]    pos_ext;
    logic [CNT_W:0]    cnt_plus;
    logic              ins_ok;
    logic              rd_ok;
    logic [CNT_W-1:0]  at_full;

    plc_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(plc_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // position checks
    assign pos_ext  = {1'b0, request.position};
    assign cnt_plus = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign ins_ok   = (request.position != '0) && (pos_ext <= cnt_plus);
    assign rd_ok    = (request.position != '0) && (request.position <= count_reg);
    assign at_full  = request.position - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plc_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        at_reg     <= at_next;
        ch_reg     <= ch_next;
        ins_reg    <= ins_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        at_next     = at_reg;
        ch_next     = ch_reg;
        ins_next    = ins_reg;
        pend_next   = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = dst_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = src_reg;

        case (state_reg)
            plc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    done_next                  = 1'b1;
                    result_next.status         = plc_pkg::STAT_INVALID;
                    result_next.read_character = '0;
                    result_next.list_length    = count_reg;
                    at_next                    = at_full[ADDR_W-1:0];
                    ch_next                    = request.character;
                    case (request.operation)
                        plc_pkg::OP_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                if (count_reg == CAP)
                                begin
                                    result_next.status = plc_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    done_next  = 1'b0;
                                    ins_next   = 1'b1;
                                    src_next   = ADDR_W'(count_reg - CNT_W'(1));
                                    left_next  = count_reg - at_full;
                                    state_next = plc_pkg::S_SHIFT;
                                end
                            end
                        end
                        plc_pkg::OP_DELETE:
                        begin
                            if (rd_ok)
                            begin
                                done_next  = 1'b0;
                                ins_next   = 1'b0;
                                src_next   = request.position[ADDR_W-1:0];
                                left_next  = count_reg - request.position;
                                state_next = plc_pkg::S_SHIFT;
                            end
                        end
                        plc_pkg::OP_READ:
                        begin
                            if (rd_ok)
                            begin
                                done_next  = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = at_full[ADDR_W-1:0];
                                state_next = plc_pkg::S_READ;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            plc_pkg::S_SHIFT:
            begin
                // issue the next move read while the previous one is written back
                if (left_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_reg;
                    pend_next = 1'b1;
                    left_next = left_reg - CNT_W'(1);
                    if (ins_reg)
                    begin
                        dst_next = src_reg + ADDR_W'(1);
                        src_next = src_reg - ADDR_W'(1);
                    end
                    else
                    begin
                        dst_next = src_reg - ADDR_W'(1);
                        src_next = src_reg + ADDR_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if ((left_reg == '0) && !pend_reg)
                begin
                    if (ins_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = at_reg;
                        ram_wdata  = ch_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    done_next                  = 1'b1;
                    result_next.status         = plc_pkg::STAT_OK;
                    result_next.read_character = '0;
                    result_next.list_length    = count_next;
                    state_next                 = plc_pkg::S_IDLE;
                end
            end

            plc_pkg::S_READ:
            begin
                done_next                  = 1'b1;
                result_next.status         = plc_pkg::STAT_OK;
                result_next.read_character = ram_rdata;
                result_next.list_length    = count_reg;
                state_next                 = plc_pkg::S_IDLE;
            end

            default:
            begin
                state_next = plc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != plc_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("list length above capacity");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && (state_reg == plc_pkg::S_IDLE)))
        else $error("memory write while idle");

    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg)
        else $error("length changed without a result");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == plc_pkg::STAT_FULL))
        |-> (result_reg.list_length == CAP))
        else $error("full reported below capacity");

    a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == plc_pkg::S_SHIFT))
        else $error("pending move outside shift");

endmodule
